// File: hw/rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Types and constants shared by the start-byte/mask message deframer.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned KIND_W  = 2;

    localparam logic [BYTE_W-1:0] SOH_BYTE  = 8'h01;
    localparam logic [BYTE_W-1:0] MASK_BITS = 8'h7F;

    localparam logic [BYTE_W-1:0] MASK_BYTE8  = 8'd64;
    localparam logic [BYTE_W-1:0] MASK_WORD32 = 8'd32;
    localparam logic [BYTE_W-1:0] MASK_WORD16 = 8'd16;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_MASK  = 3'd2,
        PH_DATA8 = 3'd3,
        PH_HIGH  = 3'd4,
        PH_LOW   = 3'd5
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE   = 2'd0,
        KIND_WORD32 = 2'd1,
        KIND_WORD16 = 2'd2
    } t_kind;

endpackage

// File: hw/rtl/soh_mask_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// soh_mask_message_deframer_unit
// Hunts for a pair of start bytes, decodes the mask byte and emits one
// message word per complete frame.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the slave stream (i_s_tdata, one byte per word).
//   Each complete message leaves on the master stream: o_m_tdata carries the
//   16-bit value (one-byte messages in the low byte, high byte zero) and
//   o_m_tuser carries the kind (0 = one-byte, 1 = mask 32, 2 = mask 16).
//   A byte is captured in an input register and decoded by the parser state
//   machine once the output register is free or being read. A finished
//   message is loaded into the output register as its last byte is
//   consumed, and o_m_tvalid is driven from that register.
//   Throughput is one byte per cycle unless a message is stalled. Both
//   registers are held only while a message waits in the output register and
//   the receiver holds i_m_tready low; o_s_tready then falls once the input
//   register is full. Reset returns the parser to hunting with no start
//   byte seen and empties both registers.
// ----------------------------------------------------------------------------
module soh_mask_message_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [smd_pkg::BYTE_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [smd_pkg::VALUE_W-1:0]   o_m_tdata,   // [15:0] msg_value
    output logic [smd_pkg::KIND_W-1:0]    o_m_tuser    // [1:0] msg_kind
);

    logic                          r_in_vld;
    logic [smd_pkg::BYTE_W-1:0]    r_in_byte;
    smd_pkg::t_phase               r_phase, n_phase;
    smd_pkg::t_kind                r_pend_kind, n_pend_kind;
    logic [smd_pkg::BYTE_W-1:0]    r_high, n_high;
    logic                          r_out_vld;
    logic [smd_pkg::VALUE_W-1:0]   r_out_value;
    smd_pkg::t_kind                r_out_kind;

    logic                          consume;
    logic                          emit;
    smd_pkg::t_kind                emit_kind;
    logic [smd_pkg::VALUE_W-1:0]   emit_value;
    logic [smd_pkg::BYTE_W-1:0]    mask;
    logic                          is_soh;

    assign consume    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || consume;
    assign mask       = r_in_byte & smd_pkg::MASK_BITS;
    assign is_soh     = (r_in_byte == smd_pkg::SOH_BYTE);

    always_comb begin
        n_phase     = r_phase;
        n_pend_kind = r_pend_kind;
        n_high      = r_high;
        emit        = 1'b0;
        emit_kind   = smd_pkg::KIND_BYTE;
        emit_value  = {{(smd_pkg::VALUE_W-smd_pkg::BYTE_W){1'b0}}, r_in_byte};
        case (r_phase)
            smd_pkg::PH_HUNT1: begin
                n_phase = is_soh ? smd_pkg::PH_MASK : smd_pkg::PH_HUNT0;
            end
            smd_pkg::PH_MASK: begin
                if (mask == smd_pkg::MASK_BYTE8) begin
                    n_phase = smd_pkg::PH_DATA8;
                end else if (mask == smd_pkg::MASK_WORD32) begin
                    n_pend_kind = smd_pkg::KIND_WORD32;
                    n_phase     = smd_pkg::PH_HIGH;
                end else if (mask == smd_pkg::MASK_WORD16) begin
                    n_pend_kind = smd_pkg::KIND_WORD16;
                    n_phase     = smd_pkg::PH_HIGH;
                end else begin
                    // A raw start byte in the mask slot pairs with the one before it.
                    n_phase = is_soh ? smd_pkg::PH_MASK : smd_pkg::PH_HUNT0;
                end
            end
            smd_pkg::PH_DATA8: begin
                n_phase = smd_pkg::PH_HUNT0;
                emit    = 1'b1;
            end
            smd_pkg::PH_HIGH: begin
                n_high  = r_in_byte;
                n_phase = smd_pkg::PH_LOW;
            end
            smd_pkg::PH_LOW: begin
                n_phase    = smd_pkg::PH_HUNT0;
                emit       = 1'b1;
                emit_kind  = r_pend_kind;
                emit_value = {r_high, r_in_byte};
            end
            default: begin
                n_phase = is_soh ? smd_pkg::PH_HUNT1 : smd_pkg::PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_phase     <= smd_pkg::PH_HUNT0;
            r_pend_kind <= smd_pkg::KIND_BYTE;
            r_high      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (consume) begin
                r_phase     <= n_phase;
                r_pend_kind <= n_pend_kind;
                r_high      <= n_high;
            end
            if (consume && emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (consume && emit) begin
            r_out_value <= emit_value;
            r_out_kind  <= emit_kind;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_kind;

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == smd_pkg::KIND_BYTE)
                        || (o_m_tuser == smd_pkg::KIND_WORD32)
                        || (o_m_tuser == smd_pkg::KIND_WORD16)))
        else $error("deframer emitted an undefined message kind");

    a_byte_msg_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == smd_pkg::KIND_BYTE))
            |-> (o_m_tdata[smd_pkg::VALUE_W-1:smd_pkg::BYTE_W] == '0))
        else $error("one-byte message carries a nonzero high byte");

    a_last_byte_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && ((r_phase == smd_pkg::PH_DATA8) || (r_phase == smd_pkg::PH_LOW)))
            |=> (o_m_tvalid && (r_phase == smd_pkg::PH_HUNT0)))
        else $error("final frame byte did not produce a message and rehunt");

    a_no_consume_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |-> !consume)
        else $error("parser advanced while a message was stalled");

endmodule

// File: dv/soh_mask_message_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// soh_mask_message_deframer_unit_tb
// Streams received bytes into the deframer and checks every decoded message.
// A model of the parser runs in step with the input handshake and queues the
// messages it decodes. The checker compares each output word against the
// oldest queued message. The sender runs in random bursts and the receiver
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module soh_mask_message_deframer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 1100;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct packed {
        smd_pkg::t_kind              kind;
        logic [smd_pkg::VALUE_W-1:0] value;
    } t_msg;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [smd_pkg::BYTE_W-1:0]    i_s_tdata  = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [smd_pkg::VALUE_W-1:0]   o_m_tdata;
    logic [smd_pkg::KIND_W-1:0]    o_m_tuser;

    // Parser state of the model.
    smd_pkg::t_phase            frame_phase = smd_pkg::PH_HUNT0;
    smd_pkg::t_kind             word_kind   = smd_pkg::KIND_BYTE;
    logic [smd_pkg::BYTE_W-1:0] word_high   = '0;

    t_msg        pending_msgs[$];
    int unsigned error_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    soh_mask_message_deframer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Advances the parser model by one byte; returns 1 when a message completes.
    function automatic bit decode_rx_byte(input logic [smd_pkg::BYTE_W-1:0] b,
                                          output t_msg msg);
        logic [smd_pkg::BYTE_W-1:0] m;
        bit                         done;
        done = 1'b0;
        msg  = '0;
        m    = b & smd_pkg::MASK_BITS;
        case (frame_phase)
            smd_pkg::PH_HUNT1: begin
                frame_phase = (b == smd_pkg::SOH_BYTE) ? smd_pkg::PH_MASK : smd_pkg::PH_HUNT0;
            end
            smd_pkg::PH_MASK: begin
                if (m == smd_pkg::MASK_BYTE8) begin
                    frame_phase = smd_pkg::PH_DATA8;
                end else if (m == smd_pkg::MASK_WORD32) begin
                    word_kind   = smd_pkg::KIND_WORD32;
                    frame_phase = smd_pkg::PH_HIGH;
                end else if (m == smd_pkg::MASK_WORD16) begin
                    word_kind   = smd_pkg::KIND_WORD16;
                    frame_phase = smd_pkg::PH_HIGH;
                end else begin
                    // A raw start byte in the mask slot pairs with the one before it.
                    frame_phase = (b == smd_pkg::SOH_BYTE) ? smd_pkg::PH_MASK
                                                           : smd_pkg::PH_HUNT0;
                end
            end
            smd_pkg::PH_DATA8: begin
                msg.kind    = smd_pkg::KIND_BYTE;
                msg.value   = {8'h00, b};
                done        = 1'b1;
                frame_phase = smd_pkg::PH_HUNT0;
            end
            smd_pkg::PH_HIGH: begin
                word_high   = b;
                frame_phase = smd_pkg::PH_LOW;
            end
            smd_pkg::PH_LOW: begin
                msg.kind    = word_kind;
                msg.value   = {word_high, b};
                done        = 1'b1;
                frame_phase = smd_pkg::PH_HUNT0;
            end
            default: begin
                frame_phase = (b == smd_pkg::SOH_BYTE) ? smd_pkg::PH_HUNT1 : smd_pkg::PH_HUNT0;
            end
        endcase
        return done;
    endfunction

    // Sends one byte; the sender works in bursts separated by random gaps.
    task automatic send_byte(input logic [smd_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [smd_pkg::BYTE_W-1:0] seq[]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    function automatic logic [smd_pkg::BYTE_W-1:0] rand_data_byte();
        return ($urandom_range(0, 9) == 0) ? smd_pkg::SOH_BYTE : 8'($urandom_range(0, 255));
    endfunction

    task automatic test_byte_messages();
        // Mask with its top bit set still selects the one-byte message.
        send_seq('{smd_pkg::SOH_BYTE, smd_pkg::SOH_BYTE, smd_pkg::MASK_BYTE8 | 8'h80, 8'h00});
    endtask

    task automatic test_word_messages();
        send_seq('{smd_pkg::SOH_BYTE, smd_pkg::SOH_BYTE, smd_pkg::MASK_WORD32, 8'hFF, 8'hFF});
        // A start byte inside the payload is plain data.
        send_seq('{smd_pkg::SOH_BYTE, smd_pkg::SOH_BYTE, smd_pkg::MASK_WORD16 | 8'h80, 8'h00,
                   smd_pkg::SOH_BYTE});
    endtask

    task automatic test_resync();
        // Three start bytes in a row, then a one-byte message.
        send_seq('{smd_pkg::SOH_BYTE, smd_pkg::SOH_BYTE, smd_pkg::SOH_BYTE,
                   smd_pkg::MASK_BYTE8, 8'hFF});
        // A single start byte followed by something else.
        send_seq('{smd_pkg::SOH_BYTE, 8'h05});
        // Masks to one but is not a start byte, so hunting restarts.
        send_seq('{smd_pkg::SOH_BYTE, smd_pkg::SOH_BYTE, 8'h81});
        send_byte(8'h7F);
    endtask

    task automatic test_random_frames();
        int unsigned                target;
        int unsigned                sel;
        int unsigned                soh_count;
        logic [smd_pkg::BYTE_W-1:0] mask;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            sel       = $urandom_range(0, 9);
            soh_count = (sel < 8) ? 2 : ((sel == 8) ? 1 : 3);
            repeat (soh_count) send_byte(smd_pkg::SOH_BYTE);
            if ($urandom_range(0, 9) < 8) begin
                case ($urandom_range(0, 2))
                    0:       mask = smd_pkg::MASK_BYTE8;
                    1:       mask = smd_pkg::MASK_WORD32;
                    default: mask = smd_pkg::MASK_WORD16;
                endcase
                mask[7] = 1'($urandom_range(0, 1));
            end else begin
                mask = 8'($urandom_range(0, 255));
            end
            send_byte(mask);
            if ((mask & smd_pkg::MASK_BITS) == smd_pkg::MASK_BYTE8) begin
                send_byte(rand_data_byte());
            end else if ((mask & smd_pkg::MASK_BITS) == smd_pkg::MASK_WORD32 ||
                         (mask & smd_pkg::MASK_BITS) == smd_pkg::MASK_WORD16) begin
                send_byte(rand_data_byte());
                send_byte(rand_data_byte());
            end
        end
    endtask

    // Receiver back-pressure: a new stall mode and pattern are drawn whenever the current mode runs out.
    always @(negedge i_clk) begin : rx_stall
        static int unsigned mode      = 0;
        static int unsigned mode_left = 0;
        static logic [7:0]  pattern   = 8'hFF;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
            pattern   = 8'($urandom_range(1, 255));
        end
        mode_left--;
        case (mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= 1'($urandom_range(0, 1));
            2: begin
                i_m_tready <= pattern[0];
                pattern     = {pattern[0], pattern[7:1]};
            end
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Runs the model on each accepted byte and checks each output word.
    always @(posedge i_clk) begin : check
        t_msg exp_msg;
        t_msg new_msg;
        bit   in_acc;
        bit   out_acc;
        if (i_rst_n) begin
            in_acc  = i_s_tvalid && o_s_tready;
            out_acc = o_m_tvalid && i_m_tready;
            if (out_acc) begin
                if (pending_msgs.size() == 0) begin
                    $display("%0t: unexpected message: expected none, got kind %0d value %h",
                             $time, o_m_tuser, o_m_tdata);
                    error_count++;
                end else begin
                    exp_msg = pending_msgs.pop_front();
                    if (o_m_tuser !== exp_msg.kind) begin
                        $display("%0t: kind mismatch: expected %0d, got %0d",
                                 $time, exp_msg.kind, o_m_tuser);
                        error_count++;
                    end
                    if (o_m_tdata !== exp_msg.value) begin
                        $display("%0t: value mismatch: expected %h, got %h",
                                 $time, exp_msg.value, o_m_tdata);
                        error_count++;
                    end
                end
            end
            if (in_acc) begin
                if (decode_rx_byte(i_s_tdata, new_msg)) pending_msgs.push_back(new_msg);
            end
            if (in_acc || out_acc) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_byte_messages();
        test_word_messages();
        test_resync();
        test_random_frames();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
